>>> rtl/csc_pkg.sv
package csc_pkg;

  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned WINDOW_BYTES = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned WINDOW_W     = 64;
  localparam int unsigned GAP_W        = 64;

  // Result word: all status fields packed from bit 0, padded to whole bytes
  localparam int unsigned RESULT_BITS  = 2 + 5 * WORD_W + GAP_W;
  localparam int unsigned OUT_TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;

  // Bit offsets of the fields inside the result word
  localparam int unsigned OFS_IN_SYNC  = 0;
  localparam int unsigned OFS_EVER     = 1;
  localparam int unsigned OFS_EXPECT   = 2;
  localparam int unsigned OFS_FIRST    = OFS_EXPECT + WORD_W;
  localparam int unsigned OFS_GOOD     = OFS_FIRST + WORD_W;
  localparam int unsigned OFS_LOSSES   = OFS_GOOD + WORD_W;
  localparam int unsigned OFS_SKIPPED  = OFS_LOSSES + WORD_W;
  localparam int unsigned OFS_LOST     = OFS_SKIPPED + WORD_W;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                  sync;
    logic                  ever_sync;
    logic [WORD_W-1:0]     expected;
    logic [WORD_W-1:0]     partial_word;
    logic [1:0]            partial_count;
    logic [WINDOW_W-1:0]   window;
    logic [3:0]            window_fill;
    logic [WORD_W-1:0]     first_seen;
    logic [WORD_W-1:0]     match_count;
    logic [WORD_W-1:0]     loss_count;
    logic [WORD_W-1:0]     skip_count;
    logic [GAP_W-1:0]      gap_total;
  } chk_state_t;

endpackage

>>> rtl/csc_step.sv
module csc_step (
  input  csc_pkg::chk_state_t cur,
  input  csc_pkg::cmd_t       cmd,
  input  logic [7:0]          data_byte,
  output csc_pkg::chk_state_t nxt
);

  logic [csc_pkg::WORD_W-1:0]   word;
  logic [csc_pkg::WORD_W-1:0]   lo;
  logic [csc_pkg::WORD_W-1:0]   hi;
  logic [csc_pkg::WORD_W-1:0]   diff;
  logic [csc_pkg::GAP_W-1:0]    diff_ext;
  logic [csc_pkg::WINDOW_W-1:0] win;
  logic [3:0]                   fill;

  always_comb begin
    nxt      = cur;
    word     = cur.partial_word
               | ({24'd0, data_byte} << {cur.partial_count, 3'b000});
    win      = {data_byte, cur.window[csc_pkg::WINDOW_W-1:8]};
    fill     = (cur.window_fill < 4'(csc_pkg::WINDOW_BYTES))
               ? 4'(cur.window_fill + 4'd1) : cur.window_fill;
    lo       = win[csc_pkg::WORD_W-1:0];
    hi       = win[csc_pkg::WINDOW_W-1:csc_pkg::WORD_W];
    diff     = lo - cur.expected;
    diff_ext = {{(csc_pkg::GAP_W-csc_pkg::WORD_W){diff[csc_pkg::WORD_W-1]}}, diff};

    if (cmd == csc_pkg::CMD_CLEAR) begin
      nxt = '0;
    end else if (cur.sync) begin
      // Assemble the word, little-endian
      if (cur.partial_count != 2'(csc_pkg::WORD_BYTES - 1)) begin
        nxt.partial_word  = word;
        nxt.partial_count = 2'(cur.partial_count + 2'd1);
      end else begin
        nxt.partial_word  = '0;
        nxt.partial_count = '0;
        if (word == cur.expected) begin
          nxt.expected    = cur.expected + 32'd1;
          nxt.match_count = cur.match_count + 32'd1;
        end else begin
          // Drop sync and restart the search from the bad word
          nxt.sync        = 1'b0;
          nxt.loss_count  = cur.loss_count + 32'd1;
          nxt.window      = {word, {csc_pkg::WORD_W{1'b0}}};
          nxt.window_fill = 4'(csc_pkg::WORD_BYTES);
        end
      end
    end else begin
      nxt.window      = win;
      nxt.window_fill = fill;
      if (fill == 4'(csc_pkg::WINDOW_BYTES)) begin
        if (hi != lo + 32'd1) begin
          nxt.skip_count = cur.skip_count + 32'd1;
        end else begin
          if (cur.ever_sync) begin
            nxt.gap_total = cur.gap_total + {diff_ext[csc_pkg::GAP_W-3:0], 2'b00};
          end else begin
            nxt.first_seen = lo;
            nxt.ever_sync  = 1'b1;
          end
          nxt.match_count = cur.match_count + 32'd2;
          nxt.expected    = hi + 32'd1;
          nxt.sync        = 1'b1;
          nxt.window_fill = '0;
        end
      end
    end
  end

endmodule

>>> rtl/counter_stream_checker.sv
// Incrementing-counter stream checker.
//
// Input channel (s_axis_*): one word per stream byte. tdata carries the byte,
// tuser selects the command: 0 checks the byte, 1 clears every counter and
// the sync state (the byte is then ignored).
// Output channel (m_axis_*): exactly one status word per input word, in
// order, showing the checker state after that input word was applied.
//
// Each accepted byte is held in the input register, then passes through the
// update logic into the output register. Throughput: one word per cycle while
// the receiver takes each status word; the update of the whole checker state
// is a single pass of compares and adds, so the next byte can follow in the
// next cycle.
//
// Reset (rst, synchronous, active high) empties both registers and clears
// all checker state, as a clear command does.
// When the receiver stalls, the status word holds and the input register
// keeps one byte in reserve; s_axis_tready drops only once both are full.
module counter_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte
  input  logic [7:0]                       s_axis_tdata,
  // [0] cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] in_sync, [1] sync_seen, [33:2] next_expected,
  // [65:34] first_value, [97:66] good_words, [129:98] sync_losses,
  // [161:130] skipped_bytes, [225:162] lost_bytes, [231:226] zero
  output logic [csc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Input register
  logic                in_valid;
  csc_pkg::cmd_t       in_cmd;
  logic [7:0]          in_byte;

  // Checker state and output register
  csc_pkg::chk_state_t st;
  csc_pkg::chk_state_t st_next;
  logic                out_valid;
  logic [csc_pkg::OUT_TDATA_W-1:0] out_data;
  logic [csc_pkg::OUT_TDATA_W-1:0] out_data_next;

  logic advance;

  // Move the held byte into the output stage whenever that stage is free
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  csc_step u_step (
    .cur       (st),
    .cmd       (in_cmd),
    .data_byte (in_byte),
    .nxt       (st_next)
  );

  // Pack the snapshot of the updated state, first field lowest
  always_comb begin
    out_data_next = '0;
    out_data_next[csc_pkg::OFS_IN_SYNC] = st_next.sync;
    out_data_next[csc_pkg::OFS_EVER]    = st_next.ever_sync;
    out_data_next[csc_pkg::OFS_EXPECT  +: csc_pkg::WORD_W] = st_next.expected;
    out_data_next[csc_pkg::OFS_FIRST   +: csc_pkg::WORD_W] = st_next.first_seen;
    out_data_next[csc_pkg::OFS_GOOD    +: csc_pkg::WORD_W] = st_next.match_count;
    out_data_next[csc_pkg::OFS_LOSSES  +: csc_pkg::WORD_W] = st_next.loss_count;
    out_data_next[csc_pkg::OFS_SKIPPED +: csc_pkg::WORD_W] = st_next.skip_count;
    out_data_next[csc_pkg::OFS_LOST    +: csc_pkg::GAP_W]  = st_next.gap_total;
  end

  // Control and checker state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      // Commit the new state only as the byte leaves the input register
      if (advance && in_valid) begin
        st <= st_next;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= csc_pkg::cmd_t'(s_axis_tuser);
      in_byte <= s_axis_tdata;
    end
    if (advance && in_valid) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

>>> rtl/csc_checker.sv
module csc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [csc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic ever;
  logic no_history;

  assign ever       = m_axis_tdata[csc_pkg::OFS_EVER];
  assign no_history =
    (m_axis_tdata[csc_pkg::OFS_GOOD   +: csc_pkg::WORD_W] == '0) &&
    (m_axis_tdata[csc_pkg::OFS_LOSSES +: csc_pkg::WORD_W] == '0) &&
    (m_axis_tdata[csc_pkg::OFS_LOST   +: csc_pkg::GAP_W]  == '0);

  // Nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("status word valid after reset");

  // A stalled status word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("status word changed while stalled");

  // Sync implies sync was found at some point
  a_sync_ever: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[csc_pkg::OFS_IN_SYNC] || ever))
    else $error("in sync without ever having synced");

  // Before the first sync no word can have matched, been lost or gapped
  a_no_history: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !ever |-> no_history)
    else $error("counters moved before first sync");

  // An empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind counter_stream_checker csc_checker u_csc_checker (.*);
